/* sv/rle_image_stream_decoder_defines.svh */
// Assertion macros used by the checker file risd_checker.sv.
`ifndef RLE_IMAGE_STREAM_DECODER_DEFINES_SVH
`define RLE_IMAGE_STREAM_DECODER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RISD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rle decoder check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define RISD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rle decoder check failed");

`endif

/* sv/risd_pkg.sv */
package risd_pkg;

	// Image sizes and beat width
	localparam int LARGE_IMAGE_BYTES = 16384;
	localparam int SMALL_IMAGE_BYTES = 8192;
	localparam int BYTES_PER_BEAT    = 8;
	localparam int MAX_IMAGE_BYTES   = (LARGE_IMAGE_BYTES > SMALL_IMAGE_BYTES) ?
		LARGE_IMAGE_BYTES : SMALL_IMAGE_BYTES;
	localparam int BW_WIDTH          = $clog2(MAX_IMAGE_BYTES + 1);

	// Result status codes
	localparam logic [2:0] STS_DATA       = 3'd0;
	localparam logic [2:0] STS_DONE       = 3'd1;
	localparam logic [2:0] STS_BAD_HEADER = 3'd2;
	localparam logic [2:0] STS_OVERFLOW   = 3'd3;
	localparam logic [2:0] STS_TRAILING   = 3'd4;
	localparam logic [2:0] STS_TRUNCATED  = 3'd5;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_TOKEN,
		PH_LITERAL,
		PH_REPEAT
	} phase_t;

	typedef enum logic [1:0] {
		CD_ACTIVE,
		CD_FULL,
		CD_DISCARD
	} cond_t;

	typedef enum logic {
		ST_TAKE,
		ST_BURST
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic beat;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;
		logic take_more;
		logic run_final;
	} sts_t;

	// Expected header byte for a format and position
	function automatic logic [7:0] head_byte(input logic fmt, input logic [2:0] pos);
		logic [7:0] v;
		case (pos)
			3'd0: v = fmt ? 8'h48 : 8'h44;
			3'd1: v = fmt ? 8'h47 : 8'h48;
			3'd2: v = 8'h52;
			3'd3: v = 8'h52;
			3'd4: v = 8'h01;
			3'd5: v = 8'h00;
			3'd6: v = 8'h00;
			3'd7: v = fmt ? 8'h20 : 8'h40;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Bytes in the next beat of a run
	function automatic logic [3:0] beat_take(input logic [7:0] left);
		logic [3:0] c;
		if (left < 8'(BYTES_PER_BEAT)) begin
			c = left[3:0];
		end else begin
			c = 4'(BYTES_PER_BEAT);
		end
		return c;
	endfunction

	// Replicate a byte into the low lanes of a beat
	function automatic logic [63:0] beat_word(input logic [7:0] val, input logic [3:0] c);
		logic [63:0] w;
		w = '0;
		for (int j = 0; j < 8; j++) begin
			if (4'(j) < c) begin
				w[8*j +: 8] = val;
			end
		end
		return w;
	endfunction

endpackage

/* sv/risd_ctrl.sv */
module risd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  risd_pkg::sts_t  sts,
	output risd_pkg::cmd_t  cmd
);

	risd_pkg::state_t state_q;
	risd_pkg::state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= risd_pkg::ST_TAKE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx   = state_q;
		cmd        = '0;
		byte_stall = 1'b1;
		case (state_q)
			risd_pkg::ST_TAKE: begin
				// take a request whenever the output slot can load
				byte_stall = !sts.slot_free;
				if (byte_valid && sts.slot_free) begin
					cmd.take = 1'b1;
					if (sts.take_more) begin
						state_nx = risd_pkg::ST_BURST;
					end
				end
			end
			risd_pkg::ST_BURST: begin
				// advance the repeat one beat per free slot
				if (sts.slot_free) begin
					cmd.beat = 1'b1;
					if (sts.run_final) begin
						state_nx = risd_pkg::ST_TAKE;
					end
				end
			end
			default: begin
				state_nx = risd_pkg::ST_TAKE;
			end
		endcase
	end

endmodule

/* sv/risd_datapath.sv */
module risd_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic            cfg_fmt,
	input  logic [7:0]      stream_byte,
	input  logic            end_of_stream,
	input  risd_pkg::cmd_t  cmd,
	output risd_pkg::sts_t  sts,
	output logic            beat_valid,
	input  logic            beat_stall,
	output logic [63:0]     out_bytes,
	output logic [3:0]      byte_count,
	output logic [2:0]      status,
	output logic            last
);

	localparam int BW = risd_pkg::BW_WIDTH;

	logic               fmt_q;
	logic [2:0]         hp_q;
	risd_pkg::phase_t   phase_q;
	logic [7:0]         lit_q;
	logic [7:0]         rep_q;
	logic [BW-1:0]      bw_q;
	risd_pkg::cond_t    cond_q;

	logic [7:0]         run_val_q;
	logic [7:0]         run_left_q;
	logic [2:0]         run_stat_q;

	logic               out_valid_q;
	logic [63:0]        out_bytes_q;
	logic [3:0]         out_cnt_q;
	logic [2:0]         out_stat_q;
	logic               out_last_q;

	logic [2:0]         hp_nx;
	risd_pkg::phase_t   phase_nx;
	logic [7:0]         lit_nx;
	logic [7:0]         rep_nx;
	logic [BW-1:0]      bw_nx;
	risd_pkg::cond_t    cond_nx;

	logic [BW-1:0]      size;
	logic [BW-1:0]      room;
	logic [8:0]         len;
	logic [7:0]         count;
	logic [BW-1:0]      bw_sum;
	logic [2:0]         s;
	logic [7:0]         emit;
	logic               has_result;
	logic [3:0]         c0;
	logic [7:0]         rem0;
	logic               final0;
	logic [3:0]         cb;
	logic [7:0]         remb;
	logic               finalb;
	logic               slot_free;

	// Image size and room left, saturating at zero
	assign size = fmt_q ? BW'(risd_pkg::SMALL_IMAGE_BYTES) : BW'(risd_pkg::LARGE_IMAGE_BYTES);
	assign room = (bw_q < size) ? (size - bw_q) : '0;

	// Decode one request against the stream state
	always_comb begin
		hp_nx    = hp_q;
		phase_nx = phase_q;
		lit_nx   = lit_q;
		rep_nx   = rep_q;
		bw_nx    = bw_q;
		cond_nx  = cond_q;
		s        = risd_pkg::STS_DATA;
		emit     = 8'd0;
		len      = stream_byte[7] ? (9'(stream_byte[6:0]) + 9'd3) : (9'(stream_byte) + 9'd1);
		count    = (phase_q == risd_pkg::PH_LITERAL) ? 8'd1 : rep_q;
		bw_sum   = bw_q + BW'(count);
		case (cond_q)
			risd_pkg::CD_DISCARD: begin
				// drop silently
			end
			risd_pkg::CD_FULL: begin
				s = risd_pkg::STS_TRAILING;
			end
			default: begin
				case (phase_q)
					risd_pkg::PH_HEADER: begin
						if (stream_byte != risd_pkg::head_byte(fmt_q, hp_q)) begin
							s = risd_pkg::STS_BAD_HEADER;
						end else begin
							hp_nx = hp_q + 3'd1;
							if (hp_q == 3'd7) begin
								phase_nx = risd_pkg::PH_TOKEN;
							end
							if (end_of_stream) begin
								s = risd_pkg::STS_TRUNCATED;
							end
						end
					end
					risd_pkg::PH_TOKEN: begin
						if (end_of_stream) begin
							s = risd_pkg::STS_TRUNCATED;
						end else if (BW'(len) > room) begin
							s = risd_pkg::STS_OVERFLOW;
						end else if (stream_byte[7]) begin
							rep_nx   = len[7:0];
							phase_nx = risd_pkg::PH_REPEAT;
						end else begin
							lit_nx   = len[7:0];
							phase_nx = risd_pkg::PH_LITERAL;
						end
					end
					default: begin
						// literal byte or repeat value
						if ((BW'(count) > room) || (count == 8'd0)) begin
							s = risd_pkg::STS_OVERFLOW;
						end else begin
							emit  = count;
							bw_nx = bw_sum;
							if (phase_q == risd_pkg::PH_LITERAL) begin
								if (lit_q <= 8'd1) begin
									lit_nx   = 8'd0;
									phase_nx = risd_pkg::PH_TOKEN;
								end else begin
									lit_nx = lit_q - 8'd1;
								end
							end else begin
								rep_nx   = 8'd0;
								phase_nx = risd_pkg::PH_TOKEN;
							end
							if (bw_sum >= size) begin
								if (end_of_stream) begin
									s = risd_pkg::STS_DONE;
								end else begin
									cond_nx = risd_pkg::CD_FULL;
								end
							end else if (end_of_stream) begin
								s = risd_pkg::STS_TRUNCATED;
							end
						end
					end
				endcase
			end
		endcase
		// restart at the end of the stream, discard after an error
		if (end_of_stream) begin
			hp_nx    = 3'd0;
			phase_nx = risd_pkg::PH_HEADER;
			lit_nx   = 8'd0;
			rep_nx   = 8'd0;
			bw_nx    = '0;
			cond_nx  = risd_pkg::CD_ACTIVE;
		end else if (s != risd_pkg::STS_DATA) begin
			cond_nx = risd_pkg::CD_DISCARD;
		end
	end

	// First beat of this request and next beat of a pending run
	assign has_result = (emit != 8'd0) || (s != risd_pkg::STS_DATA);
	assign c0         = risd_pkg::beat_take(emit);
	assign rem0       = emit - 8'(c0);
	assign final0     = (rem0 == 8'd0);
	assign cb         = risd_pkg::beat_take(run_left_q);
	assign remb       = run_left_q - 8'(cb);
	assign finalb     = (remb == 8'd0);
	assign slot_free  = !out_valid_q || !beat_stall;

	assign sts.slot_free = slot_free;
	assign sts.take_more = has_result && !final0;
	assign sts.run_final = finalb;

	// Format register and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= 1'b0;
			hp_q       <= 3'd0;
			phase_q    <= risd_pkg::PH_HEADER;
			lit_q      <= 8'd0;
			rep_q      <= 8'd0;
			bw_q       <= '0;
			cond_q     <= risd_pkg::CD_ACTIVE;
			run_left_q <= 8'd0;
		end else begin
			if (cfg_valid) begin
				fmt_q <= cfg_fmt;
			end
			if (cmd.take) begin
				hp_q       <= hp_nx;
				phase_q    <= phase_nx;
				lit_q      <= lit_nx;
				rep_q      <= rep_nx;
				bw_q       <= bw_nx;
				cond_q     <= cond_nx;
				run_left_q <= rem0;
			end else if (cmd.beat) begin
				run_left_q <= remb;
			end
		end
	end

	// Hold run value and final status for a burst
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			run_val_q  <= stream_byte;
			run_stat_q <= s;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take && has_result) || cmd.beat) begin
			out_valid_q <= 1'b1;
		end else if (!beat_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.take && has_result) begin
			out_bytes_q <= risd_pkg::beat_word(stream_byte, c0);
			out_cnt_q   <= c0;
			out_stat_q  <= final0 ? s : risd_pkg::STS_DATA;
			out_last_q  <= final0 && (s != risd_pkg::STS_DATA);
		end else if (cmd.beat) begin
			out_bytes_q <= risd_pkg::beat_word(run_val_q, cb);
			out_cnt_q   <= cb;
			out_stat_q  <= finalb ? run_stat_q : risd_pkg::STS_DATA;
			out_last_q  <= finalb && (run_stat_q != risd_pkg::STS_DATA);
		end
	end

	assign beat_valid = out_valid_q;
	assign out_bytes  = out_bytes_q;
	assign byte_count = out_cnt_q;
	assign status     = out_stat_q;
	assign last       = out_last_q;

endmodule

/* sv/rle_image_stream_decoder.sv */
// Channel  Direction  Handshake                Payload
// byte     in         byte_valid / byte_stall  stream_byte, end_of_stream
// beat     out        beat_valid / beat_stall  out_bytes, byte_count, status, last
// cfg      in         cfg_valid / cfg_ready    image_format
//
// Header, token and literal bytes are each taken as soon as the output register can load.
// A repeat value byte yields ceil(n/8) beats for a run of n bytes, up to 17 for 130,
// from the single output register that loads one beat per cycle unless beat_stall holds it.
// Reset clears the stream state and selects the large format; no clearing pass.
// A stalled beat holds the output register and, in turn, stalls the byte channel.
module rle_image_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  stream_byte,
	input  logic        end_of_stream,
	output logic        beat_valid,
	input  logic        beat_stall,
	output logic [63:0] out_bytes,
	output logic [3:0]  byte_count,
	output logic [2:0]  status,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        image_format
);

	risd_pkg::cmd_t cmd;
	risd_pkg::sts_t sts;

	// Format writes are always accepted and registered
	assign cfg_ready = 1'b1;

	risd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	risd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_fmt       (image_format),
		.stream_byte   (stream_byte),
		.end_of_stream (end_of_stream),
		.cmd           (cmd),
		.sts           (sts),
		.beat_valid    (beat_valid),
		.beat_stall    (beat_stall),
		.out_bytes     (out_bytes),
		.byte_count    (byte_count),
		.status        (status),
		.last          (last)
	);

endmodule

/* sv/risd_checker.sv */
`include "rle_image_stream_decoder_defines.svh"

module risd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        beat_valid,
	input logic        beat_stall,
	input logic [63:0] out_bytes,
	input logic [3:0]  byte_count,
	input logic [2:0]  status,
	input logic        last
);

	// A beat never carries more than one full word of bytes
	`RISD_ASSERT_NOW(a_count_range, beat_valid, byte_count <= 4'd8)

	// A final status and the last flag go together
	`RISD_ASSERT_NOW(a_last_status, beat_valid, last == (status != risd_pkg::STS_DATA))

	// A pure status result is empty and closes the stream
	`RISD_ASSERT_NOW(a_pure_status, beat_valid && (byte_count == 4'd0),
		(out_bytes == 64'd0) && last)

	// A stalled beat holds
	`RISD_ASSERT_NEXT(a_beat_hold, beat_valid && beat_stall,
		beat_valid && $stable(out_bytes) && $stable(byte_count) && $stable(status))

endmodule

bind rle_image_stream_decoder risd_checker u_risd_checker (.*);

/* tb/sv/rle_image_stream_decoder_checker.sv */
`timescale 1ns / 100ps

module rle_image_stream_decoder_checker
	import risd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  stream_byte,
	input  logic        end_of_stream,
	input  logic        beat_valid,
	input  logic        beat_stall,
	input  logic [63:0] out_bytes,
	input  logic [3:0]  byte_count,
	input  logic [2:0]  status,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        image_format,
	output int          mismatch_count,
	output int          beats_due
);

	typedef struct {
		logic [63:0] data;
		logic [3:0]  count;
		logic [2:0]  status;
		logic        last;
	} beat_t;

	// Header signature per format: large first, small second
	localparam logic [7:0] SIGNATURE [2][8] = '{
		'{8'h44, 8'h48, 8'h52, 8'h52, 8'h01, 8'h00, 8'h00, 8'h40},
		'{8'h48, 8'h47, 8'h52, 8'h52, 8'h01, 8'h00, 8'h00, 8'h20}
	};

	beat_t       due_beats[$];
	logic        fmt_small;
	logic [3:0]  hdr_pos;
	phase_t      phase;
	logic [7:0]  literal_left;
	logic [7:0]  run_length;
	logic [14:0] written;
	cond_t       cond;

	// Return the stream state to its reset values; the format is kept
	function automatic void restart_stream();
		hdr_pos      = '0;
		phase        = PH_HEADER;
		literal_left = '0;
		run_length   = '0;
		written      = '0;
		cond         = CD_ACTIVE;
	endfunction

	// Decode one accepted stream byte and queue the beats it produces
	function automatic void decode_stream_byte(input logic [7:0] b, input logic eos);
		int         size;
		int         room;
		int         count;
		int         left;
		int         chunk;
		int         made;
		logic [2:0] verdict;
		beat_t      beat;
		size    = fmt_small ? SMALL_IMAGE_BYTES : LARGE_IMAGE_BYTES;
		room    = (int'(written) < size) ? size - int'(written) : 0;
		verdict = STS_DATA;
		made    = 0;

		// Drop everything after an error until the stream ends
		if (cond == CD_DISCARD) begin
			if (eos) begin
				restart_stream();
			end
			return;
		end

		if (cond == CD_FULL) begin
			verdict = STS_TRAILING;
		end else if (phase == PH_HEADER) begin
			if (b != SIGNATURE[fmt_small][hdr_pos[2:0]]) begin
				verdict = STS_BAD_HEADER;
			end else begin
				hdr_pos = {1'b0, hdr_pos[2:0]} + 4'd1;
				if (hdr_pos >= 4'd8) begin
					phase = PH_TOKEN;
				end
				if (eos) begin
					verdict = STS_TRUNCATED;
				end
			end
		end else if (phase == PH_TOKEN) begin
			count = b[7] ? int'(b[6:0]) + 3 : int'(b) + 1;
			if (eos) begin
				verdict = STS_TRUNCATED;
			end else if (count > room) begin
				verdict = STS_OVERFLOW;
			end else if (b[7]) begin
				run_length = 8'(count);
				phase      = PH_REPEAT;
			end else begin
				literal_left = 8'(count);
				phase        = PH_LITERAL;
			end
		end else begin
			count = (phase == PH_LITERAL) ? 1 : int'(run_length);
			if (count > room || count == 0) begin
				verdict = STS_OVERFLOW;
			end else begin
				// Split the run into beats of up to eight bytes
				left = count;
				while (left > 0) begin
					chunk       = (left < BYTES_PER_BEAT) ? left : BYTES_PER_BEAT;
					beat.data   = '0;
					for (int j = 0; j < chunk; j++) begin
						beat.data[8*j +: 8] = b;
					end
					beat.count  = 4'(chunk);
					beat.status = STS_DATA;
					beat.last   = 1'b0;
					due_beats.insert(due_beats.size(), beat);
					made++;
					left -= chunk;
				end
				written = written + 15'(count);
				if (phase == PH_LITERAL) begin
					if (literal_left <= 8'd1) begin
						literal_left = '0;
						phase        = PH_TOKEN;
					end else begin
						literal_left = literal_left - 8'd1;
					end
				end else begin
					run_length = '0;
					phase      = PH_TOKEN;
				end
				if (int'(written) >= size) begin
					if (eos) begin
						verdict = STS_DONE;
					end else begin
						cond = CD_FULL;
					end
				end else if (eos) begin
					verdict = STS_TRUNCATED;
				end
			end
		end

		// Carry a final status on the last data beat, or alone
		if (verdict != STS_DATA) begin
			if (made > 0) begin
				due_beats[due_beats.size() - 1].status = verdict;
				due_beats[due_beats.size() - 1].last   = 1'b1;
			end else begin
				beat.data   = '0;
				beat.count  = '0;
				beat.status = verdict;
				beat.last   = 1'b1;
				due_beats.insert(due_beats.size(), beat);
			end
		end
		if (eos) begin
			restart_stream();
		end else if (verdict != STS_DATA) begin
			cond = CD_DISCARD;
		end
	endfunction

	// Predict on each byte request, compare each beat request, track the format
	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		int    bad;
		if (!arst_n) begin
			fmt_small = 1'b0;
			restart_stream();
			due_beats.delete();
			mismatch_count <= 0;
			beats_due      <= 0;
		end else begin
			bad = 0;
			if (byte_valid && !byte_stall) begin
				decode_stream_byte(stream_byte, end_of_stream);
			end
			if (beat_valid && !beat_stall) begin
				if (due_beats.size() == 0) begin
					$error("beat with nothing expected: out_bytes %0h byte_count %0d status %0d last %0b",
						out_bytes, byte_count, status, last);
					bad++;
				end else begin
					want = due_beats.pop_front();
					if (out_bytes !== want.data) begin
						$error("out_bytes: expected %0h, got %0h", want.data, out_bytes);
						bad++;
					end
					if (byte_count !== want.count) begin
						$error("byte_count: expected %0d, got %0d", want.count, byte_count);
						bad++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						bad++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						bad++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				fmt_small = image_format;
			end
			mismatch_count <= mismatch_count + bad;
			beats_due      <= due_beats.size();
		end
	end

endmodule

/* tb/sv/rle_image_stream_decoder_tb.sv */
`timescale 1ns / 100ps

module rle_image_stream_decoder_tb;
	import risd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int STREAM_ITEMS = 380;

	// Header signature per format: large first, small second
	localparam logic [7:0] SIGNATURE [2][8] = '{
		'{8'h44, 8'h48, 8'h52, 8'h52, 8'h01, 8'h00, 8'h00, 8'h40},
		'{8'h48, 8'h47, 8'h52, 8'h52, 8'h01, 8'h00, 8'h00, 8'h20}
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        byte_valid    = 1'b0;
	logic        byte_stall;
	logic [7:0]  stream_byte   = 8'h00;
	logic        end_of_stream = 1'b0;
	logic        beat_valid;
	logic        beat_stall    = 1'b0;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic [2:0]  status;
	logic        last;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        image_format  = 1'b0;
	int          mismatch_count;
	int          beats_due;

	int          items_sent = 0;
	int          image_fill = 0;
	int          sink_wait  = 0;
	logic        cur_small  = 1'b0;
	logic        src_quiet  = 1'b0;
	logic        sink_quiet = 1'b0;

	rle_image_stream_decoder i_dut (
		.clk,
		.arst_n,
		.byte_valid,
		.byte_stall,
		.stream_byte,
		.end_of_stream,
		.beat_valid,
		.beat_stall,
		.out_bytes,
		.byte_count,
		.status,
		.last,
		.cfg_valid,
		.cfg_ready,
		.image_format
	);

	rle_image_stream_decoder_checker i_checker (
		.clk,
		.arst_n,
		.byte_valid,
		.byte_stall,
		.stream_byte,
		.end_of_stream,
		.beat_valid,
		.beat_stall,
		.out_bytes,
		.byte_count,
		.status,
		.last,
		.cfg_valid,
		.cfg_ready,
		.image_format,
		.mismatch_count,
		.beats_due
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Stall each beat at random, unless the sink is quiet
	always @(posedge clk) begin
		if (arst_n) begin
			if (beat_valid && !beat_stall) begin
				sink_wait = sink_quiet ? 0 : $urandom_range(0, 5);
				beat_stall <= (sink_wait != 0);
			end else if (beat_valid && beat_stall) begin
				sink_wait = sink_wait - 1;
				beat_stall <= (sink_wait > 0);
			end
		end
	end

	// Stop a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// Issue one byte request after a random gap and wait for its acceptance
	task automatic send_byte(input logic [7:0] value, input logic eos);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid    <= 1'b1;
		stream_byte   <= value;
		end_of_stream <= eos;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		items_sent++;
	endtask

	// Drop the byte channel and wait until every beat has come out
	task automatic wait_idle(input int settle);
		byte_valid <= 1'b0;
		@(posedge clk);
		while (beats_due != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_format(input logic small_fmt);
		wait_idle(4);
		cfg_valid    <= 1'b1;
		image_format <= small_fmt;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_small = small_fmt;
	endtask

	// Send the first count header bytes of a format
	task automatic send_header(input logic small_fmt, input int count, input logic eos_last);
		for (int i = 0; i < count; i++) begin
			send_byte(SIGNATURE[small_fmt][i], eos_last && (i == count - 1));
		end
	endtask

	// Write tokens until the image holds exactly target bytes
	task automatic fill_to(input int target, input logic eos_last);
		int room;
		int cap;
		int len;
		while (image_fill < target) begin
			room = target - image_fill;
			cap  = (room < 130) ? room : 130;
			if (room > 300) begin
				// Cover the bulk of a big image with the longest runs
				send_byte(8'hFF, 1'b0);
				image_fill += 130;
				send_byte(8'($urandom), 1'b0);
			end else if (room >= 3 && $urandom_range(0, 4) != 0) begin
				len = ($urandom_range(0, 1) == 1) ? cap : $urandom_range(3, cap);
				send_byte(8'h80 | 8'(len - 3), 1'b0);
				image_fill += len;
				send_byte(8'($urandom), eos_last && (image_fill == target));
			end else begin
				len = $urandom_range(1, (room < 4) ? room : 4);
				send_byte(8'(len - 1), 1'b0);
				repeat (len) begin
					image_fill++;
					send_byte(8'($urandom), eos_last && (image_fill == target));
				end
			end
		end
	endtask

	// Close a broken stream with a few bytes the block drops
	task automatic discard_tail();
		repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
	endtask

	initial begin
		int   pos;
		int   room;
		int   len;
		logic eos;
		logic [7:0] value;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bad first header byte, then the end of the stream
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// End inside the header
		send_header(1'b0, 3, 1'b1);
		// Longest literal token on the end of the stream
		send_header(1'b0, 8, 1'b0);
		send_byte(8'h7F, 1'b1);
		// Longest repeat, ended on its value byte
		send_header(1'b0, 8, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b1);

		// Full images interleaved with short broken streams
		for (int k = 0; items_sent < STREAM_ITEMS || k < 16; k++) begin
			src_quiet  = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			image_fill = 0;
			if (k % 4 == 0 && k < 16) begin
				case (k / 4)
					0: begin
						// Complete small image ended on its last byte
						set_format(1'b1);
						send_header(1'b1, 8, 1'b0);
						fill_to(SMALL_IMAGE_BYTES, 1'b1);
					end
					1: begin
						// Full image followed by a trailing byte
						set_format(1'b1);
						send_header(1'b1, 8, 1'b0);
						fill_to(SMALL_IMAGE_BYTES, 1'b0);
						eos = 1'($urandom_range(0, 1));
						send_byte(8'($urandom), eos);
						if (!eos) begin
							discard_tail();
						end
					end
					2: begin
						// Run token longer than the room left
						set_format(1'b1);
						send_header(1'b1, 8, 1'b0);
						room = $urandom_range(1, 129);
						fill_to(SMALL_IMAGE_BYTES - room, 1'b0);
						len = $urandom_range(room + 1, 130);
						send_byte(8'h80 | 8'(len - 3), 1'b0);
						discard_tail();
					end
					default: begin
						// Shrink the format under a pending repeat
						set_format(1'b0);
						send_header(1'b0, 8, 1'b0);
						fill_to(SMALL_IMAGE_BYTES - 60 + $urandom_range(0, 120), 1'b0);
						room = (image_fill < SMALL_IMAGE_BYTES) ? SMALL_IMAGE_BYTES - image_fill : 0;
						len  = $urandom_range((room + 1 < 3) ? 3 : room + 1, 130);
						send_byte(8'h80 | 8'(len - 3), 1'b0);
						set_format(1'b1);
						send_byte(8'($urandom), 1'b0);
						discard_tail();
					end
				endcase
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					set_format(1'($urandom_range(0, 1)));
				end
				case ($urandom_range(0, 3))
					0: begin
						// Random noise as a stream
						repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
						send_byte(8'($urandom), 1'b1);
					end
					1: begin
						// Header cut short or broken at a random position
						pos = $urandom_range(1, 8);
						send_header(cur_small, pos - 1, 1'b0);
						if ($urandom_range(0, 1) == 1) begin
							send_byte(SIGNATURE[cur_small][pos - 1], 1'b1);
						end else begin
							value = SIGNATURE[cur_small][pos - 1] ^ 8'($urandom_range(1, 255));
							eos   = 1'($urandom_range(0, 1));
							send_byte(value, eos);
							if (!eos) begin
								discard_tail();
							end
						end
					end
					2: begin
						// Short body ended on data or on a token
						send_header(cur_small, 8, 1'b0);
						eos = 1'($urandom_range(0, 1));
						fill_to($urandom_range(1, 300), eos);
						if (!eos) begin
							send_byte(8'($urandom), 1'b1);
						end
					end
					default: begin
						// Header of the other format
						send_header(!cur_small, 8, 1'b0);
						discard_tail();
					end
				endcase
			end
		end

		wait_idle(20);
		if (mismatch_count == 0 && beats_due == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/risd_pkg.sv
sv/risd_ctrl.sv
sv/risd_datapath.sv
sv/rle_image_stream_decoder.sv
sv/risd_checker.sv
tb/sv/rle_image_stream_decoder_checker.sv
tb/sv/rle_image_stream_decoder_tb.sv
